[rtl/core/strided_broadcast_tile_index_generator_macros.svh]
// Assertion helper macros for the tile index generator
`ifndef STRIDED_BROADCAST_TILE_INDEX_GENERATOR_MACROS_SVH
`define STRIDED_BROADCAST_TILE_INDEX_GENERATOR_MACROS_SVH

// Implication checked every cycle outside reset
`define SBT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent
`define SBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/sbtig_pkg.sv]
// ----------------------------------------------------------------------------
// sbtig_pkg
// Shared types and constants of the strided broadcast tile index generator.
// ----------------------------------------------------------------------------
`default_nettype none
package sbtig_pkg;
  localparam int IDX_W  = 32;
  localparam int DIM_W  = 16;
  localparam int PLN_W  = 24;
  localparam int CFG_IW = 3;
  localparam int QDEPTH = 2;

  typedef enum logic [CFG_IW-1:0] {
    REG_OUTER_STRIDE = 3'd0, REG_DEPTH_STRIDE = 3'd1, REG_BATCH_STRIDE = 3'd2,
    REG_CHANNEL_STRIDE = 3'd3, REG_DEPTH_COUNT = 3'd4, REG_BATCH_COUNT = 3'd5,
    REG_CHANNEL_COUNT = 3'd6, REG_PLANE_TILES = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {CMD_READ = 2'd0, CMD_WRITE = 2'd1, CMD_NONE = 2'd2}
    cmd_t;
  typedef enum logic [1:0] {PH_IDLE = 2'd0, PH_READ = 2'd1, PH_WRITE = 2'd2} phase_t;
  typedef enum logic [2:0] {
    FS_IDLE, FS_DIV, FS_MUL, FS_SUM, FS_PUSH
  } fstate_t;

  // live configuration
  typedef struct packed {
    logic [IDX_W-1:0] outer_stride;
    logic [IDX_W-1:0] depth_stride;
    logic [IDX_W-1:0] batch_stride;
    logic [IDX_W-1:0] channel_stride;
    logic [DIM_W-1:0] depth_count;
    logic [DIM_W-1:0] batch_count;
    logic [DIM_W-1:0] channel_count;
    logic [PLN_W-1:0] plane_tiles;
  } cfg_t;

  // queue entry from front to back: a classified item
  typedef struct packed {
    logic             is_start;
    logic             live;       // start leaves a running job
    logic [IDX_W-1:0] src;
    logic [DIM_W-1:0] outer_i;
    logic [DIM_W-1:0] depth_i;
    logic [DIM_W-1:0] batch_i;
    logic [DIM_W-1:0] chan_i;
    logic [PLN_W-1:0] plane_i;
    logic [IDX_W-1:0] start_tile;
    logic [IDX_W-1:0] total;
    logic [DIM_W-1:0] outer_tot;
  } job_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [IDX_W-1:0] tile_index;
    logic             last;
  } res_t;
endpackage
`default_nettype wire

[rtl/core/sbtig_divider.sv]
// ----------------------------------------------------------------------------
// sbtig_divider
// Radix-2 restoring divider, 32-bit dividend by 24-bit divisor, one bit/cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module sbtig_divider (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       go,
  input  wire logic [sbtig_pkg::IDX_W-1:0] dividend,
  input  wire logic [sbtig_pkg::PLN_W-1:0] divisor,
  output logic                            done,
  output logic [sbtig_pkg::IDX_W-1:0]      quot,
  output logic [sbtig_pkg::PLN_W-1:0]      rem
);
  import sbtig_pkg::*;
  localparam int CW = $clog2(IDX_W + 1);

  logic [CW-1:0]    cnt;
  logic             busy;
  logic [PLN_W:0]   r;
  logic [PLN_W:0]   trial;
  logic [PLN_W-1:0] dv;

  assign trial = {r[PLN_W-1:0], quot[IDX_W-1]} - {1'b0, dv};

  // one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= CW'(IDX_W);
        quot <= dividend;
        r    <= '0;
        dv   <= divisor;
      end else if (busy) begin
        if (trial[PLN_W]) begin
          r    <= {r[PLN_W-1:0], quot[IDX_W-1]};
          quot <= {quot[IDX_W-2:0], 1'b0};
        end else begin
          r    <= trial;
          quot <= {quot[IDX_W-2:0], 1'b1};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign rem = r[PLN_W-1:0];
endmodule
`default_nettype wire

[rtl/core/sbtig_front.sv]
// ----------------------------------------------------------------------------
// sbtig_front
// Accepts input beats; splits start tiles and forms the source offset.
// ----------------------------------------------------------------------------
`default_nettype none
module sbtig_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire sbtig_pkg::cfg_t              cfg,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         in_kind,
  input  wire logic [sbtig_pkg::IDX_W-1:0]  in_first,
  input  wire logic [sbtig_pkg::IDX_W-1:0]  in_total,
  input  wire logic [sbtig_pkg::DIM_W-1:0]  in_outer,
  output logic                              q_valid,
  input  wire logic                         q_ready,
  output sbtig_pkg::job_t                   q_data
);
  import sbtig_pkg::*;

  fstate_t state, state_next;
  job_t    job;
  logic [2:0] step;
  logic [IDX_W-1:0] num, prod;
  logic [PLN_W-1:0] den;
  logic [IDX_W-1:0] p_out, p_dep, p_bat, p_chn;
  logic [DIM_W-1:0] sdc, sbc, scc;
  logic [PLN_W-1:0] spt;
  logic [IDX_W-1:0] s_nd;
  logic div_go, div_start, div_done;
  logic [IDX_W-1:0] dq;
  logic [PLN_W-1:0] dr;
  logic [1:0] mstep;

  // divider is started by the registered request, once num, step and counts settle
  sbtig_divider u_div (
    .clk(clk), .rst(rst), .go(div_start), .dividend(num), .divisor(den),
    .done(div_done), .quot(dq), .rem(dr)
  );

  // divisor for each split step, zero counts act as one
  always_comb begin
    unique case (step)
      3'd0:    den = (spt == '0) ? PLN_W'(1) : spt;
      3'd1:    den = PLN_W'((scc == '0) ? DIM_W'(1) : scc);
      3'd2:    den = PLN_W'((sbc == '0) ? DIM_W'(1) : sbc);
      default: den = PLN_W'((sdc == '0) ? DIM_W'(1) : sdc);
    endcase
  end

  // one stride product per cycle
  always_comb begin
    unique case (mstep)
      2'd0:    prod = s_nd * cfg.outer_stride;
      2'd1:    prod = IDX_W'(job.depth_i) * cfg.depth_stride;
      2'd2:    prod = IDX_W'(job.batch_i) * cfg.batch_stride;
      default: prod = IDX_W'(job.chan_i) * cfg.channel_stride;
    endcase
  end

  assign in_ready = (state == FS_IDLE) && !(q_valid && !q_ready);
  assign q_data   = job;

  // state register and delayed divider start
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FS_IDLE;
      div_start <= 1'b0;
    end else begin
      state     <= state_next;
      div_start <= div_go;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    div_go = 1'b0;
    unique case (state)
      FS_IDLE: if (in_valid && in_ready && !in_kind) begin
        state_next = FS_DIV;
        div_go = 1'b1;
      end
      FS_DIV:  if (div_done) begin
        if (step == 3'd3) state_next = FS_MUL;
        else div_go = 1'b1;
      end
      FS_MUL:  if (mstep == 2'd3) state_next = FS_SUM;
      FS_SUM:  state_next = FS_PUSH;
      FS_PUSH: if (!q_valid || q_ready) state_next = FS_IDLE;
      default: state_next = FS_IDLE;
    endcase
  end

  // datapath and queue output register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else begin
      if (q_valid && q_ready) q_valid <= 1'b0;
      unique case (state)
        FS_IDLE: if (in_valid && in_ready) begin
          if (in_kind) begin
            job.is_start <= 1'b0;
            q_valid <= 1'b1;
          end else begin
            sdc <= cfg.depth_count; sbc <= cfg.batch_count;
            scc <= cfg.channel_count; spt <= cfg.plane_tiles;
            job.start_tile <= in_first; job.total <= in_total;
            job.outer_tot <= in_outer;
            num <= in_first; step <= 3'd0; job.src <= '0;
          end
        end
        FS_DIV: if (div_done) begin
          unique case (step)
            3'd0:    job.plane_i <= dr;
            3'd1:    job.chan_i  <= dr[DIM_W-1:0];
            3'd2:    job.batch_i <= dr[DIM_W-1:0];
            default: begin
              job.depth_i <= dr[DIM_W-1:0];
              s_nd <= dq;
            end
          endcase
          num <= dq; step <= step + 3'd1; mstep <= 2'd0;
        end
        FS_MUL: begin
          job.src <= job.src + prod;
          mstep <= mstep + 2'd1;
        end
        FS_SUM: begin
          job.outer_i  <= s_nd[DIM_W-1:0];
          job.is_start <= 1'b1;
          job.live <= (job.total != '0) && (s_nd < IDX_W'(job.outer_tot));
        end
        FS_PUSH: if (!q_valid || q_ready) q_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  `include "strided_broadcast_tile_index_generator_macros.svh"
  `SBT_ASSERT_IMP(a_div_only_busy, div_done, state == FS_DIV, "divider done outside split")
  `SBT_ASSERT_IMP(a_no_accept_busy, state != FS_IDLE, !in_ready, "accept while splitting")
  `SBT_ASSERT_NEXT(a_push_valid, state == FS_PUSH && state_next == FS_IDLE, q_valid && q_data.is_start, "start not queued")
endmodule
`default_nettype wire

[rtl/core/sbtig_back.sv]
// ----------------------------------------------------------------------------
// sbtig_back
// Executes queued items: read/write sequencing and stride carries.
// ----------------------------------------------------------------------------
`default_nettype none
module sbtig_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sbtig_pkg::cfg_t cfg,
  input  wire logic            q_valid,
  output logic                 q_ready,
  input  wire sbtig_pkg::job_t q_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output sbtig_pkg::res_t      out_data
);
  import sbtig_pkg::*;

  phase_t phase;
  logic [IDX_W-1:0] src, wr, st, tot;
  logic [DIM_W-1:0] oi, di, bi, ci, ot;
  logic [PLN_W-1:0] pi;
  logic [DIM_W-1:0] dc, bc, cc;
  logic [PLN_W-1:0] pt;
  logic [IDX_W-1:0] wr_n;
  logic [PLN_W-1:0] pi_n;
  logic cnt_end, pl_end, shp_end;
  // pending carry: 0 none, else deferred correction level
  logic [2:0] carry;
  logic [IDX_W-1:0] corr;

  assign dc = (cfg.depth_count == '0) ? DIM_W'(1) : cfg.depth_count;
  assign bc = (cfg.batch_count == '0) ? DIM_W'(1) : cfg.batch_count;
  assign cc = (cfg.channel_count == '0) ? DIM_W'(1) : cfg.channel_count;
  assign pt = (cfg.plane_tiles == '0) ? PLN_W'(1) : cfg.plane_tiles;
  assign wr_n = wr + 1'b1;
  assign pi_n = pi + 1'b1;
  assign cnt_end = wr_n == tot;
  assign pl_end  = pi_n >= pt;
  assign shp_end = pl_end && ({1'b0, ci} + 1'b1 >= {1'b0, cc})
                 && ({1'b0, bi} + 1'b1 >= {1'b0, bc})
                 && ({1'b0, di} + 1'b1 >= {1'b0, dc})
                 && ({1'b0, oi} + 1'b1 >= {1'b0, ot});

  // correction product for a carry into a higher dimension, one per cycle
  always_comb begin
    unique case (carry)
      3'd1:    corr = cfg.channel_stride * IDX_W'(cc);
      3'd2:    corr = cfg.batch_stride * IDX_W'(bc);
      3'd3:    corr = cfg.depth_stride * IDX_W'(dc);
      default: corr = '0;
    endcase
  end

  assign q_ready = (!out_valid || out_ready) && (carry == 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      out_valid <= 1'b0;
      carry <= 3'd0;
      src <= '0; wr <= '0; st <= '0; tot <= '0; ot <= '0;
      oi <= '0; di <= '0; bi <= '0; ci <= '0; pi <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (carry != 3'd0) begin
        // finish the multi-level carry before the next beat
        priority if (carry == 3'd1 && ci == cc) begin
          ci <= '0; bi <= bi + 1'b1; src <= src - corr + cfg.batch_stride;
          carry <= ((bi + 1'b1) < bc) ? 3'd0 : 3'd2;
        end else if (carry == 3'd2) begin
          bi <= '0; di <= di + 1'b1; src <= src - corr + cfg.depth_stride;
          carry <= ((di + 1'b1) < dc) ? 3'd0 : 3'd3;
        end else if (carry == 3'd3) begin
          di <= '0; oi <= oi + 1'b1; src <= src - corr + cfg.outer_stride;
          carry <= 3'd0;
        end else begin
          carry <= 3'd0;
        end
      end else if (q_valid && q_ready) begin
        out_valid <= 1'b1;
        out_data.command <= CMD_NONE;
        out_data.tile_index <= '0;
        out_data.last <= 1'b0;
        if (q_data.is_start) begin
          src <= q_data.src; oi <= q_data.outer_i; di <= q_data.depth_i;
          bi <= q_data.batch_i; ci <= q_data.chan_i; pi <= q_data.plane_i;
          st <= q_data.start_tile; tot <= q_data.total; ot <= q_data.outer_tot;
          wr <= '0;
          phase <= q_data.live ? PH_READ : PH_IDLE;
        end else begin
          unique case (phase)
            PH_READ: begin
              out_data.command <= CMD_READ;
              out_data.tile_index <= src;
              phase <= PH_WRITE;
            end
            PH_WRITE: begin
              out_data.command <= CMD_WRITE;
              out_data.tile_index <= st + wr;
              out_data.last <= cnt_end || shp_end;
              wr <= wr_n; pi <= pi_n;
              if (cnt_end || shp_end) begin
                phase <= PH_IDLE;
              end else if (pl_end) begin
                pi <= '0;
                src <= src + cfg.channel_stride;
                phase <= PH_READ;
                ci <= ci + 1'b1;
                if ({1'b0, ci} + 1'b1 >= {1'b0, cc}) carry <= 3'd1;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  `include "strided_broadcast_tile_index_generator_macros.svh"
  `SBT_ASSERT_IMP(a_no_take_in_carry, carry != 3'd0, !q_ready, "beat taken during carry")
  `SBT_ASSERT_IMP(a_last_is_write, out_valid && out_data.last, out_data.command == CMD_WRITE, "last on non-write")
  `SBT_ASSERT_NEXT(a_last_idles, q_valid && q_ready && !q_data.is_start && phase == PH_WRITE && (cnt_end || shp_end), phase == PH_IDLE, "job did not end")
endmodule
`default_nettype wire

[rtl/core/strided_broadcast_tile_index_generator.sv]
// ----------------------------------------------------------------------------
// strided_broadcast_tile_index_generator
// Tile-index command generator for a scalar-broadcast copy job.
// ----------------------------------------------------------------------------
// channel   dir  fields
// s_axis    in   tuser: kind; tdata: first_tile, tile_total, outer_total
// m_axis    out  tdata: command, tile_index; tlast: last
// cfg       in   cfg_we, cfg_index, cfg_data
// Advance beats: one result per cycle while m_axis is ready, registered through the front
// output, the queue and the back output; the input stalls while a plane end carries
// into batch, depth or outer (correction multiply). Start beats: the input stalls
// while the split runs through the shared bit-serial divider (four divisions) and
// four stride multiplies before the result is queued. rst is synchronous;
// a two-deep front/back queue lets either side stall on its own.
`default_nettype none
module strided_broadcast_tile_index_generator (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [79:0]  s_axis_tdata,  // first_tile, tile_total, outer_total
  input  wire logic         s_axis_tuser,  // kind
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [39:0]       m_axis_tdata,  // command, tile_index, zero pad
  output logic              m_axis_tlast   // last
);
  import sbtig_pkg::*;

  cfg_t cfg;
  job_t fq_data, bq_data;
  job_t qmem [QDEPTH];
  logic fq_valid, fq_ready, bq_valid, bq_ready;
  logic [0:0] wp, rp;
  logic [1:0] cnt;
  res_t res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{default: '0, depth_count: DIM_W'(1), batch_count: DIM_W'(1),
               channel_count: DIM_W'(1), plane_tiles: PLN_W'(1)};
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_OUTER_STRIDE:   cfg.outer_stride   <= cfg_data;
        REG_DEPTH_STRIDE:   cfg.depth_stride   <= cfg_data;
        REG_BATCH_STRIDE:   cfg.batch_stride   <= cfg_data;
        REG_CHANNEL_STRIDE: cfg.channel_stride <= cfg_data;
        REG_DEPTH_COUNT:    cfg.depth_count    <= cfg_data[DIM_W-1:0];
        REG_BATCH_COUNT:    cfg.batch_count    <= cfg_data[DIM_W-1:0];
        REG_CHANNEL_COUNT:  cfg.channel_count  <= cfg_data[DIM_W-1:0];
        REG_PLANE_TILES:    cfg.plane_tiles    <= cfg_data[PLN_W-1:0];
        default: ;
      endcase
    end
  end

  sbtig_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_kind(s_axis_tuser),
    .in_first(s_axis_tdata[31:0]), .in_total(s_axis_tdata[63:32]),
    .in_outer(s_axis_tdata[79:64]),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
  );

  // two-entry queue between front and back
  assign fq_ready = cnt != 2'(QDEPTH);
  assign bq_valid = cnt != 2'd0;
  assign bq_data  = qmem[rp];
  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (fq_valid && fq_ready) begin
        qmem[wp] <= fq_data;
        wp <= wp + 1'b1;
      end
      if (bq_valid && bq_ready) rp <= rp + 1'b1;
      cnt <= cnt + 2'(fq_valid && fq_ready) - 2'(bq_valid && bq_ready);
    end
  end

  sbtig_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .q_valid(bq_valid), .q_ready(bq_ready), .q_data(bq_data),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(res)
  );

  assign m_axis_tdata = {6'd0, res.tile_index, res.command};
  assign m_axis_tlast = res.last;
endmodule
`default_nettype wire

[sim/tb_strided_broadcast_tile_index_generator.sv]
// ----------------------------------------------------------------------------
// tb_strided_broadcast_tile_index_generator
// Self-checking bench: directed table then random jobs, scored against an
// in-bench predictor of the tile-index command stream.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_strided_broadcast_tile_index_generator;
  import sbtig_pkg::*;

  localparam int WDOG_LIMIT = 4000;

  typedef struct packed {
    logic        kind;
    logic [31:0] first_tile;
    logic [31:0] tile_total;
    logic [15:0] outer_total;
  } beat_t;

  typedef struct packed {
    cmd_t        command;
    logic [31:0] tile_index;
    logic        last;
  } cmd_beat_t;

  typedef struct {
    beat_t     b;
    logic      known;
    cmd_beat_t r;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic m_axis_tlast;

  always #5 clk = ~clk;

  strided_broadcast_tile_index_generator i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  // predictor copy of registers and job state
  logic [31:0] r_outer_stride, r_depth_stride, r_batch_stride, r_channel_stride;
  logic [15:0] r_depth_count, r_batch_count, r_channel_count;
  logic [23:0] r_plane_tiles;
  logic [31:0] src_offset, written, job_first, job_total;
  logic [15:0] outer_i, depth_i, batch_i, chan_i, job_outer;
  logic [23:0] plane_i;
  phase_t      job_phase;

  cmd_beat_t expected_cmds[$];
  int errors = 0;
  int idle_cycles = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h", what, got, want);
  endtask

  function automatic logic [63:0] eff(input logic [63:0] v);
    return (v == 0) ? 64'd1 : v;
  endfunction

  task automatic predict_reset();
    r_outer_stride = 0; r_depth_stride = 0; r_batch_stride = 0; r_channel_stride = 0;
    r_depth_count = 1; r_batch_count = 1; r_channel_count = 1; r_plane_tiles = 1;
    src_offset = 0; written = 0; job_first = 0; job_total = 0;
    outer_i = 0; depth_i = 0; batch_i = 0; chan_i = 0; job_outer = 0; plane_i = 0;
    job_phase = PH_IDLE;
  endtask

  // next command for one input beat
  function automatic cmd_beat_t predict_cmd(input beat_t b);
    cmd_beat_t r;
    logic [63:0] dc, bc, cc, pt, q, s_t, s_c, s_n, s_d, s_nd;
    logic plane_end, shape_end, count_end;
    dc = eff(r_depth_count); bc = eff(r_batch_count);
    cc = eff(r_channel_count); pt = eff(r_plane_tiles);
    r.command = CMD_NONE; r.tile_index = 0; r.last = 1'b0;
    if (!b.kind) begin
      q = b.first_tile;
      job_first = b.first_tile; job_total = b.tile_total; job_outer = b.outer_total;
      s_t = q % pt; q = q / pt;
      s_c = q % cc; q = q / cc;
      s_n = q % bc; q = q / bc;
      s_d = q % dc; s_nd = q / dc;
      src_offset = 32'(s_nd * r_outer_stride + s_d * r_depth_stride
                       + s_n * r_batch_stride + s_c * r_channel_stride);
      plane_i = 24'(s_t); chan_i = 16'(s_c); batch_i = 16'(s_n);
      depth_i = 16'(s_d); outer_i = 16'(s_nd); written = 0;
      job_phase = (job_total == 0 || s_nd >= job_outer) ? PH_IDLE : PH_READ;
    end else if (job_phase == PH_READ) begin
      r.command = CMD_READ; r.tile_index = src_offset;
      job_phase = PH_WRITE;
    end else if (job_phase == PH_WRITE) begin
      r.command = CMD_WRITE; r.tile_index = job_first + written;
      written = written + 1;
      plane_i = plane_i + 1;
      count_end = (written == job_total);
      plane_end = (plane_i >= pt);
      shape_end = plane_end && (chan_i + 64'd1 >= cc) && (batch_i + 64'd1 >= bc)
                  && (depth_i + 64'd1 >= dc) && (outer_i + 64'd1 >= job_outer);
      r.last = count_end || shape_end;
      if (r.last) job_phase = PH_IDLE;
      else if (plane_end) begin
        plane_i = 0;
        src_offset = src_offset + r_channel_stride;
        job_phase = PH_READ;
        chan_i = chan_i + 1;
        if (chan_i >= cc) begin
          chan_i = 0;
          src_offset = src_offset + r_batch_stride - 32'(r_channel_stride * cc);
          batch_i = batch_i + 1;
          if (batch_i >= bc) begin
            batch_i = 0;
            src_offset = src_offset + r_depth_stride - 32'(r_batch_stride * bc);
            depth_i = depth_i + 1;
            if (depth_i >= dc) begin
              depth_i = 0;
              src_offset = src_offset + r_outer_stride - 32'(r_depth_stride * dc);
              outer_i = outer_i + 1;
            end
          end
        end
      end
    end
    return r;
  endfunction

  // write enable stays high across back-to-back writes; caller drops it
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_OUTER_STRIDE:   r_outer_stride = val;
      REG_DEPTH_STRIDE:   r_depth_stride = val;
      REG_BATCH_STRIDE:   r_batch_stride = val;
      REG_CHANNEL_STRIDE: r_channel_stride = val;
      REG_DEPTH_COUNT:    r_depth_count = val[15:0];
      REG_BATCH_COUNT:    r_batch_count = val[15:0];
      REG_CHANNEL_COUNT:  r_channel_count = val[15:0];
      REG_PLANE_TILES:    r_plane_tiles = val[23:0];
      default: ;
    endcase
  endtask

  // wait for drain, then let any start split finish
  task automatic settle();
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // sender: bursts with random gaps, one beat accepted per call
  int burst_left = 0;
  task automatic send(input beat_t b, input logic known, input cmd_beat_t want);
    cmd_beat_t p;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= b.kind;
    s_axis_tdata <= {b.outer_total, b.tile_total, b.first_tile};
    do @(posedge clk); while (!s_axis_tready);
    p = predict_cmd(b);
    if (known && (p != want)) report("directed table", p.tile_index, want.tile_index);
    expected_cmds.push_back(p);
  endtask

  // receiver stall pattern and scoreboard
  int stall_phase = 0;
  always @(posedge clk) begin
    cmd_beat_t w;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      m_axis_tready <= (stall_phase % 64 < 24) ? 1'b1 : ($urandom_range(0, 3) != 0);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_cmds.size() == 0) begin
          report("unexpected beat", m_axis_tdata[33:2], 0);
        end else begin
          w = expected_cmds.pop_front();
          if (m_axis_tdata[1:0] != w.command) report("command", m_axis_tdata[1:0], w.command);
          if (m_axis_tdata[33:2] != w.tile_index)
            report("tile_index", m_axis_tdata[33:2], w.tile_index);
          if (m_axis_tlast != w.last) report("last", m_axis_tlast, w.last);
        end
      end
    end
  end

  // watchdog on beats accepted by either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_LIMIT) begin
      $display("tb_strided_broadcast_tile_index_generator: FAIL");
      $finish;
    end
  end

  function automatic beat_t start_beat(input logic [31:0] ft, input logic [31:0] tt,
                                       input logic [15:0] ot);
    beat_t b;
    b.kind = 1'b0; b.first_tile = ft; b.tile_total = tt; b.outer_total = ot;
    return b;
  endfunction

  function automatic beat_t adv_beat();
    beat_t b;
    b.kind = 1'b1; b.first_tile = $urandom; b.tile_total = $urandom;
    b.outer_total = 16'($urandom);
    return b;
  endfunction

  function automatic cmd_beat_t cb(input cmd_t c, input logic [31:0] i, input logic l);
    cmd_beat_t r;
    r.command = c; r.tile_index = i; r.last = l;
    return r;
  endfunction

  row_t dir_rows[$];
  cmd_beat_t none_cmd;

  initial begin
    beat_t b;
    int njob, nadv, cnt;
    predict_reset();
    none_cmd = cb(CMD_NONE, 0, 0);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed rows at reset registers; expectations read straight off the shape
    dir_rows.push_back('{adv_beat(), 1'b1, none_cmd});                    // advance while idle
    dir_rows.push_back('{start_beat(32'd7, 32'd2, 16'd9), 1'b1, none_cmd});
    dir_rows.push_back('{adv_beat(), 1'b1, cb(CMD_READ, 0, 0)});
    dir_rows.push_back('{adv_beat(), 1'b1, cb(CMD_WRITE, 32'd7, 0)});
    dir_rows.push_back('{adv_beat(), 1'b1, cb(CMD_READ, 0, 0)});
    dir_rows.push_back('{adv_beat(), 1'b1, cb(CMD_WRITE, 32'd8, 1)});
    dir_rows.push_back('{adv_beat(), 1'b1, none_cmd});
    dir_rows.push_back('{start_beat(32'd0, 32'd0, 16'hFFFF), 1'b1, none_cmd}); // empty job
    dir_rows.push_back('{adv_beat(), 1'b1, none_cmd});
    dir_rows.push_back('{start_beat(32'd5, 32'd3, 16'd5), 1'b1, none_cmd});    // outer past
    dir_rows.push_back('{adv_beat(), 1'b1, none_cmd});
    dir_rows.push_back('{start_beat(32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF), 1'b0, none_cmd});
    dir_rows.push_back('{adv_beat(), 1'b0, none_cmd});
    dir_rows.push_back('{adv_beat(), 1'b0, none_cmd});
    dir_rows.push_back('{start_beat(32'd3, 32'd10, 16'd4), 1'b0, none_cmd}); // abandon job
    dir_rows.push_back('{adv_beat(), 1'b0, none_cmd});
    dir_rows.push_back('{adv_beat(), 1'b0, none_cmd});
    dir_rows.push_back('{adv_beat(), 1'b0, none_cmd});
    dir_rows.push_back('{adv_beat(), 1'b0, none_cmd});
    foreach (dir_rows[i]) send(dir_rows[i].b, dir_rows[i].known, dir_rows[i].r);
    s_axis_tvalid <= 1'b0; burst_left = 0;
    settle();

    // random phases, each with a fresh register setting
    cnt = 0;
    for (int ph = 0; cnt < 750; ph++) begin
      case (ph % 4)
        0: begin  // extremes
          write_reg(REG_OUTER_STRIDE, 32'hFFFFFFFF); write_reg(REG_DEPTH_STRIDE, 0);
          write_reg(REG_BATCH_STRIDE, 32'h80000000); write_reg(REG_CHANNEL_STRIDE, 32'hFFFFFFFF);
          write_reg(REG_DEPTH_COUNT, 0); write_reg(REG_BATCH_COUNT, 32'hFFFF);
          write_reg(REG_CHANNEL_COUNT, 0); write_reg(REG_PLANE_TILES, 32'hFFFFFF);
        end
        1: begin  // small counts in low bits, unused data bits set
          write_reg(REG_DEPTH_COUNT, 32'hFFFF0001); write_reg(REG_BATCH_COUNT, 32'hFFFF0002);
          write_reg(REG_CHANNEL_COUNT, 32'hFFFF0003); write_reg(REG_PLANE_TILES, 32'hFF000002);
          write_reg(REG_OUTER_STRIDE, $urandom); write_reg(REG_DEPTH_STRIDE, $urandom);
          write_reg(REG_BATCH_STRIDE, $urandom); write_reg(REG_CHANNEL_STRIDE, $urandom);
        end
        default: begin  // small random shapes
          write_reg(REG_OUTER_STRIDE, $urandom); write_reg(REG_DEPTH_STRIDE, $urandom);
          write_reg(REG_BATCH_STRIDE, $urandom); write_reg(REG_CHANNEL_STRIDE, $urandom);
          write_reg(REG_DEPTH_COUNT, $urandom_range(0, 3));
          write_reg(REG_BATCH_COUNT, $urandom_range(0, 3));
          write_reg(REG_CHANNEL_COUNT, $urandom_range(0, 4));
          write_reg(REG_PLANE_TILES, $urandom_range(0, 5));
        end
      endcase
      cfg_we <= 1'b0;
      for (njob = 0; njob < 6; njob++) begin
        case ($urandom_range(0, 9))
          0: b = start_beat($urandom, $urandom, 16'($urandom));        // noise
          1: b = start_beat($urandom_range(0, 400), 0, 16'($urandom_range(1, 5)));
          default: b = start_beat($urandom_range(0, 300), $urandom_range(1, 60),
                                  16'($urandom_range(1, 6)));
        endcase
        send(b, 1'b0, none_cmd);
        nadv = $urandom_range(5, 40);
        for (int k = 0; k < nadv; k++) send(adv_beat(), 1'b0, none_cmd);
        cnt += nadv + 1;
      end
      s_axis_tvalid <= 1'b0; burst_left = 0;
      settle();
    end

    if (errors == 0) begin
      $display("tb_strided_broadcast_tile_index_generator: PASS");
    end else begin
      $display("tb_strided_broadcast_tile_index_generator: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
